>>> src/aess_pkg.sv
// Shared types, codes and defaults of the semi-static arithmetic encoder.
package aess_pkg;

  // Default parameter values.
  localparam int unsigned DefCountWidth = 24;
  localparam int unsigned DefPendingMax = 255;
  localparam int unsigned DefScaleLimit = 16383;

  // Fixed widths of the coder and the model store.
  localparam int unsigned ScaleWidth = 14;
  localparam int unsigned CumWidth   = 15;
  localparam int unsigned ModelWidth = ScaleWidth + CumWidth;
  localparam int unsigned NumSymbols = 256;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_EXHAUSTED = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  // Kind of the next renormalization step.
  typedef enum logic [1:0] {
    RN_SHIFT_OUT,
    RN_UNDERFLOW,
    RN_DONE
  } renorm_e;

  // Datapath commands.
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CNT_INC,
    CMD_RB_INIT,
    CMD_SCAN,
    CMD_RESCAN,
    CMD_BUILD_INIT,
    CMD_BUILD,
    CMD_BUILD_END,
    CMD_MDL_LATCH,
    CMD_MUL_HI,
    CMD_DIV,
    CMD_MUL_LO,
    CMD_NARROW,
    CMD_RENORM,
    CMD_PEND,
    CMD_DEC_WR,
    CMD_ST_EMPTY,
    CMD_ST_EXH,
    CMD_ST_OVF,
    CMD_FL_B1,
    CMD_FL_B2,
    CMD_FL_PAD,
    CMD_RESTART,
    CMD_FINISH
  } dp_cmd_e;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_RB_INIT,
    S_SCAN,
    S_SCAN_END,
    S_BUILD,
    S_BUILD_END,
    S_RB_CHK,
    S_MDL_RD,
    S_MDL_CHK,
    S_MUL_HI,
    S_DIV_HI,
    S_MUL_LO,
    S_DIV_LO,
    S_NARROW,
    S_RENORM,
    S_PEND,
    S_DEC_RD,
    S_DEC_WR,
    S_OVF,
    S_EMPTY,
    S_EXH,
    S_FL_B1,
    S_FL_B2,
    S_FL_PEND,
    S_FL_PAD,
    S_FL_RESTART,
    S_FINISH
  } ctrl_state_e;

  // Input item.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] coded_byte;
    logic       last_byte;
    logic [1:0] status;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    dp_cmd_e cmd;
    logic    accept;
  } dp_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic    can_emit;
    logic    idx_end;
    logic    scan_ok;
    logic    total_zero;
    logic    exhausted;
    logic    div_last;
    renorm_e rn_kind;
    logic    pend_zero;
    logic    pend_one;
    logic    cnt_one;
    logic    ovf;
    logic    bpos_full;
  } dp_sts_t;

endpackage

>>> src/aess_ram.sv
// Generic simple dual-port RAM with registered read data.
module aess_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/aess_dp.sv
// Datapath: histogram and model stores, scaler, divider, coder and result staging.
module aess_dp #(
  parameter int unsigned COUNT_WIDTH = aess_pkg::DefCountWidth,
  parameter int unsigned PENDING_MAX = aess_pkg::DefPendingMax,
  parameter int unsigned SCALE_LIMIT = aess_pkg::DefScaleLimit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aess_pkg::dp_ctl_t ctl_i,
  output aess_pkg::dp_sts_t sts_o,
  input  logic [7:0]        symbol_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aess_pkg::out_t    out_data_o
);
  import aess_pkg::*;

  localparam int unsigned KW    = $clog2(COUNT_WIDTH);
  localparam int unsigned SUM_W = COUNT_WIDTH + 8;

  dp_cmd_e cmd;

  // Histogram store and its valid bits.
  logic [NumSymbols-1:0]  cvld_q;
  logic                   cvld_rd_q;
  logic                   cnt_we;
  logic [7:0]             cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [COUNT_WIDTH-1:0] cval;
  logic [COUNT_WIDTH-1:0] cshift;
  logic [COUNT_WIDTH-1:0] sval;
  logic [COUNT_WIDTH+13:0] sval_x;

  // Model store: cumulative bound over scaled count.
  logic                  mdl_we;
  logic [7:0]            mdl_waddr;
  logic [ModelWidth-1:0] mdl_wdata;
  logic [ModelWidth-1:0] mdl_rdata;

  // Scaler state.
  logic [7:0]       sym_q;
  logic [8:0]       idx_q;
  logic [KW-1:0]    k_q;
  logic [SUM_W-1:0] sum_q;
  logic             any_q;
  logic [14:0]      acc_q;
  logic [14:0]      total_q;
  logic [14:0]      cum_q;
  logic [13:0]      scl_q;

  // Divider and coder state.
  logic [14:0] rem_q;
  logic [16:0] bits_q;
  logic [16:0] qhi_q;
  logic [4:0]  dcnt_q;
  logic [15:0] low_q;
  logic [15:0] high_q;
  logic [7:0]  pend_q;
  logic        pbit_q;
  logic [7:0]  part_q;
  logic [2:0]  bpos_q;
  logic        ovf_q;

  // Result staging.
  logic       hold_v_q;
  logic [7:0] hold_byte_q;
  logic [1:0] hold_stat_q;
  logic       out_v_q;
  out_t       out_q;

  logic [16:0] range;
  logic [14:0] cum_hi;
  logic [14:0] mul_op;
  logic [31:0] prod;
  logic [15:0] dtrial;
  logic        dge;
  logic [15:0] ddiff;
  renorm_e     rn_kind;
  logic        emit_bit;
  logic        ebit;
  logic        res_new;
  logic [7:0]  res_byte;
  logic [1:0]  res_stat;
  logic        out_free;
  logic        can_emit;
  logic        move;

  assign cmd = ctl_i.cmd;

  aess_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NumSymbols)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (sym_q),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  aess_ram #(.WIDTH(ModelWidth), .DEPTH(NumSymbols)) u_mdl_ram (
    .clk_i   (clk_i),
    .we_i    (mdl_we),
    .waddr_i (mdl_waddr),
    .wdata_i (mdl_wdata),
    .raddr_i (sym_q),
    .rdata_o (mdl_rdata)
  );

  // Histogram read: a never-written entry reads as zero.
  assign cnt_raddr = (cmd == CMD_SCAN || cmd == CMD_BUILD) ? idx_q[7:0] : sym_q;
  assign cval      = cvld_rd_q ? cnt_rdata : '0;
  assign cshift    = cval >> k_q;
  assign sval      = (cval == '0) ? '0 : ((cshift == '0) ? COUNT_WIDTH'(1) : cshift);
  assign sval_x    = {14'd0, sval};

  // Histogram writes: saturating count, or decrement after encoding.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = cval;
    case (cmd)
      CMD_CNT_INC: begin
        cnt_we    = (cval != '1);
        cnt_wdata = cval + COUNT_WIDTH'(1);
      end
      CMD_DEC_WR: begin
        cnt_we    = (cval != '0);
        cnt_wdata = cval - COUNT_WIDTH'(1);
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // Model writes land in the cycle after the histogram read of their entry.
  assign mdl_we    = (cmd == CMD_BUILD) && (idx_q != 9'd0);
  assign mdl_waddr = idx_q[7:0] - 8'd1;
  assign mdl_wdata = {acc_q, sval_x[13:0]};

  // Interval width, one multiplier and one divider step.
  assign range  = {1'b0, high_q} - {1'b0, low_q} + 17'd1;
  assign cum_hi = cum_q + {1'b0, scl_q};
  assign mul_op = (cmd == CMD_MUL_HI) ? cum_hi : cum_q;
  assign prod   = {15'd0, range} * {17'd0, mul_op};
  assign dtrial = {rem_q, bits_q[16]};
  assign dge    = (dtrial >= {1'b0, total_q});
  assign ddiff  = dtrial - {1'b0, total_q};

  // Classify the next renormalization step.
  always_comb begin
    if (high_q[15] == low_q[15]) begin
      rn_kind = RN_SHIFT_OUT;
    end else if (low_q[14] && !high_q[14]) begin
      rn_kind = RN_UNDERFLOW;
    end else begin
      rn_kind = RN_DONE;
    end
  end

  // Bits and status results produced this cycle.
  always_comb begin
    emit_bit = 1'b0;
    ebit     = 1'b0;
    case (cmd)
      CMD_RENORM: begin
        emit_bit = (rn_kind == RN_SHIFT_OUT);
        ebit     = high_q[15];
      end
      CMD_PEND: begin
        emit_bit = 1'b1;
        ebit     = pbit_q;
      end
      CMD_FL_B1: begin
        emit_bit = 1'b1;
        ebit     = low_q[14];
      end
      CMD_FL_B2: begin
        emit_bit = 1'b1;
        ebit     = ~low_q[14];
      end
      CMD_FL_PAD: begin
        emit_bit = 1'b1;
        ebit     = 1'b1;
      end
      default: begin
        emit_bit = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_new  = emit_bit && (bpos_q == 3'd0);
    res_byte = part_q | (8'({7'd0, ebit}) << bpos_q);
    res_stat = STATUS_OK;
    case (cmd)
      CMD_ST_EMPTY: begin
        res_new  = 1'b1;
        res_byte = 8'd0;
        res_stat = STATUS_EMPTY;
      end
      CMD_ST_EXH: begin
        res_new  = 1'b1;
        res_byte = 8'd0;
        res_stat = STATUS_EXHAUSTED;
      end
      CMD_ST_OVF: begin
        res_new  = 1'b1;
        res_byte = 8'd0;
        res_stat = STATUS_OVERFLOW;
      end
      default: begin
        res_stat = STATUS_OK;
      end
    endcase
  end

  // A held result moves on when a newer one arrives or the item ends.
  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !hold_v_q || out_free;
  assign move     = hold_v_q && (res_new || cmd == CMD_FINISH);

  // Control and coder registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q   <= '0;
      low_q    <= 16'h0000;
      high_q   <= 16'hFFFF;
      pend_q   <= 8'd0;
      part_q   <= 8'd0;
      bpos_q   <= 3'd7;
      ovf_q    <= 1'b0;
      total_q  <= 15'd0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ctl_i.accept) begin
        ovf_q <= 1'b0;
      end
      if (cmd == CMD_CNT_INC || cmd == CMD_DEC_WR) begin
        cvld_q[sym_q] <= 1'b1;
      end
      if (cmd == CMD_BUILD_END) begin
        total_q <= acc_q;
      end
      if (cmd == CMD_NARROW) begin
        high_q <= low_q + qhi_q[15:0] - 16'd1;
        low_q  <= low_q + bits_q[15:0];
      end
      if (cmd == CMD_RENORM) begin
        if (rn_kind == RN_SHIFT_OUT) begin
          high_q <= {high_q[14:0], 1'b1};
          low_q  <= {low_q[14:0], 1'b0};
        end else if (rn_kind == RN_UNDERFLOW) begin
          high_q <= {1'b1, high_q[13:0], 1'b1};
          low_q  <= {1'b0, low_q[13:0], 1'b0};
          if (pend_q < 8'(PENDING_MAX)) begin
            pend_q <= pend_q + 8'd1;
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
      if (cmd == CMD_PEND) begin
        pend_q <= pend_q - 8'd1;
      end
      // Bit packer, most significant bit first.
      if (emit_bit) begin
        if (bpos_q == 3'd0) begin
          part_q <= 8'd0;
          bpos_q <= 3'd7;
        end else begin
          part_q <= res_byte;
          bpos_q <= bpos_q - 3'd1;
        end
      end
      if (cmd == CMD_RESTART) begin
        cvld_q <= '0;
        low_q  <= 16'h0000;
        high_q <= 16'hFFFF;
        pend_q <= 8'd0;
        part_q <= 8'd0;
        bpos_q <= 3'd7;
      end
      // Staging and output registers.
      if (res_new) begin
        hold_v_q <= 1'b1;
      end else if (cmd == CMD_FINISH) begin
        hold_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cvld_rd_q <= cvld_q[cnt_raddr];
    if (ctl_i.accept) begin
      sym_q <= symbol_i;
    end
    case (cmd)
      CMD_RB_INIT: begin
        idx_q <= 9'd0;
        k_q   <= '0;
        sum_q <= '0;
        any_q <= 1'b0;
      end
      CMD_RESCAN: begin
        idx_q <= 9'd0;
        k_q   <= k_q + KW'(1);
        sum_q <= '0;
        any_q <= 1'b0;
      end
      CMD_SCAN: begin
        idx_q <= idx_q + 9'd1;
        if (idx_q != 9'd0) begin
          sum_q <= sum_q + {8'd0, sval};
          any_q <= any_q || (sval > COUNT_WIDTH'(1));
        end
      end
      CMD_BUILD_INIT: begin
        idx_q <= 9'd0;
        acc_q <= 15'd0;
      end
      CMD_BUILD: begin
        idx_q <= idx_q + 9'd1;
        if (idx_q != 9'd0) begin
          acc_q <= acc_q + sval_x[14:0];
        end
      end
      CMD_MDL_LATCH: begin
        cum_q <= mdl_rdata[ModelWidth-1:ScaleWidth];
        scl_q <= mdl_rdata[ScaleWidth-1:0];
      end
      CMD_MUL_HI: begin
        rem_q  <= prod[31:17];
        bits_q <= prod[16:0];
        dcnt_q <= 5'd0;
      end
      CMD_MUL_LO: begin
        qhi_q  <= bits_q;
        rem_q  <= prod[31:17];
        bits_q <= prod[16:0];
        dcnt_q <= 5'd0;
      end
      CMD_DIV: begin
        rem_q  <= dge ? ddiff[14:0] : dtrial[14:0];
        bits_q <= {bits_q[15:0], dge};
        dcnt_q <= dcnt_q + 5'd1;
      end
      CMD_RENORM: begin
        pbit_q <= ~high_q[15];
      end
      CMD_FL_B2: begin
        pbit_q <= ~low_q[14];
      end
      default: begin
        pbit_q <= pbit_q;
      end
    endcase
    if (res_new) begin
      hold_byte_q <= res_byte;
      hold_stat_q <= res_stat;
    end
    if (move) begin
      out_q.coded_byte <= hold_byte_q;
      out_q.last_byte  <= (cmd == CMD_FINISH);
      out_q.status     <= hold_stat_q;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.can_emit   = can_emit;
    sts_o.idx_end    = (idx_q == 9'd256);
    sts_o.scan_ok    = (sum_q <= SUM_W'(SCALE_LIMIT)) || !any_q;
    sts_o.total_zero = (total_q == 15'd0);
    sts_o.exhausted  = (mdl_rdata[ScaleWidth-1:0] == '0) || (total_q == 15'd0);
    sts_o.div_last   = (dcnt_q == 5'd16);
    sts_o.rn_kind    = rn_kind;
    sts_o.pend_zero  = (pend_q == 8'd0);
    sts_o.pend_one   = (pend_q == 8'd1);
    sts_o.cnt_one    = (cval == COUNT_WIDTH'(1));
    sts_o.ovf        = ovf_q;
    sts_o.bpos_full  = (bpos_q == 3'd7);
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A staged result is never overwritten while the output is blocked.
  a_hold_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new && hold_v_q) |-> out_free)
    else $error("staged result overwritten");

  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_DIV) |-> (rem_q < total_q))
    else $error("divider remainder out of range");

  // The underflow count saturates.
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'(PENDING_MAX))
    else $error("pending bit count beyond limit");

endmodule

>>> src/aess_ctrl.sv
// Controller state machine sequencing count, rebuild, encode and flush.
module aess_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        operation_i,
  output logic              in_stall_o,
  output aess_pkg::dp_ctl_t ctl_o,
  input  aess_pkg::dp_sts_t sts_i
);
  import aess_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ready_q;
  logic        rb_dec_q;
  logic        flush_q;
  logic        accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_COUNT:  state_d = ready_q ? S_FINISH : S_CNT_RD;
            OP_ENCODE: state_d = ready_q ? S_MDL_RD : S_RB_INIT;
            default:   state_d = ready_q ? S_FL_B1 : S_EMPTY;
          endcase
        end
      end
      S_CNT_RD:    state_d = S_CNT_WR;
      S_CNT_WR:    state_d = S_FINISH;
      S_RB_INIT:   state_d = S_SCAN;
      S_SCAN:      if (sts_i.idx_end) state_d = S_SCAN_END;
      S_SCAN_END:  state_d = sts_i.scan_ok ? S_BUILD : S_SCAN;
      S_BUILD:     if (sts_i.idx_end) state_d = S_BUILD_END;
      S_BUILD_END: state_d = rb_dec_q ? S_OVF : S_RB_CHK;
      S_RB_CHK:    state_d = sts_i.total_zero ? S_EMPTY : S_MDL_RD;
      S_MDL_RD:    state_d = S_MDL_CHK;
      S_MDL_CHK:   state_d = sts_i.exhausted ? S_EXH : S_MUL_HI;
      S_MUL_HI:    state_d = S_DIV_HI;
      S_DIV_HI:    if (sts_i.div_last) state_d = S_MUL_LO;
      S_MUL_LO:    state_d = S_DIV_LO;
      S_DIV_LO:    if (sts_i.div_last) state_d = S_NARROW;
      S_NARROW:    state_d = S_RENORM;
      S_RENORM: begin
        if (sts_i.rn_kind == RN_DONE) begin
          state_d = S_DEC_RD;
        end else if (sts_i.rn_kind == RN_SHIFT_OUT && sts_i.can_emit) begin
          state_d = sts_i.pend_zero ? S_RENORM : S_PEND;
        end
      end
      S_PEND:      if (sts_i.can_emit && sts_i.pend_one) state_d = S_RENORM;
      S_DEC_RD:    state_d = S_DEC_WR;
      S_DEC_WR:    state_d = sts_i.cnt_one ? S_RB_INIT : S_OVF;
      S_OVF:       if (!sts_i.ovf || sts_i.can_emit) state_d = S_FINISH;
      S_EMPTY:     if (sts_i.can_emit) state_d = flush_q ? S_FL_RESTART : S_FINISH;
      S_EXH:       if (sts_i.can_emit) state_d = S_FINISH;
      S_FL_B1:     if (sts_i.can_emit) state_d = S_FL_B2;
      S_FL_B2: begin
        if (sts_i.can_emit) begin
          state_d = sts_i.pend_zero ? S_FL_PAD : S_FL_PEND;
        end
      end
      S_FL_PEND:   if (sts_i.can_emit && sts_i.pend_one) state_d = S_FL_PAD;
      S_FL_PAD:    if (sts_i.bpos_full) state_d = S_FL_RESTART;
      S_FL_RESTART: state_d = S_FINISH;
      S_FINISH:    if (sts_i.can_emit) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl_o.accept = accept;
    ctl_o.cmd    = CMD_NOP;
    case (state_q)
      S_CNT_WR:    ctl_o.cmd = CMD_CNT_INC;
      S_RB_INIT:   ctl_o.cmd = CMD_RB_INIT;
      S_SCAN:      ctl_o.cmd = CMD_SCAN;
      S_SCAN_END:  ctl_o.cmd = sts_i.scan_ok ? CMD_BUILD_INIT : CMD_RESCAN;
      S_BUILD:     ctl_o.cmd = CMD_BUILD;
      S_BUILD_END: ctl_o.cmd = CMD_BUILD_END;
      S_MDL_CHK:   ctl_o.cmd = sts_i.exhausted ? CMD_NOP : CMD_MDL_LATCH;
      S_MUL_HI:    ctl_o.cmd = CMD_MUL_HI;
      S_DIV_HI:    ctl_o.cmd = CMD_DIV;
      S_MUL_LO:    ctl_o.cmd = CMD_MUL_LO;
      S_DIV_LO:    ctl_o.cmd = CMD_DIV;
      S_NARROW:    ctl_o.cmd = CMD_NARROW;
      S_RENORM: begin
        if (sts_i.rn_kind == RN_UNDERFLOW ||
            (sts_i.rn_kind == RN_SHIFT_OUT && sts_i.can_emit)) begin
          ctl_o.cmd = CMD_RENORM;
        end
      end
      S_PEND:      if (sts_i.can_emit) ctl_o.cmd = CMD_PEND;
      S_DEC_WR:    ctl_o.cmd = CMD_DEC_WR;
      S_OVF:       if (sts_i.ovf && sts_i.can_emit) ctl_o.cmd = CMD_ST_OVF;
      S_EMPTY:     if (sts_i.can_emit) ctl_o.cmd = CMD_ST_EMPTY;
      S_EXH:       if (sts_i.can_emit) ctl_o.cmd = CMD_ST_EXH;
      S_FL_B1:     if (sts_i.can_emit) ctl_o.cmd = CMD_FL_B1;
      S_FL_B2:     if (sts_i.can_emit) ctl_o.cmd = CMD_FL_B2;
      S_FL_PEND:   if (sts_i.can_emit) ctl_o.cmd = CMD_PEND;
      S_FL_PAD:    if (!sts_i.bpos_full && sts_i.can_emit) ctl_o.cmd = CMD_FL_PAD;
      S_FL_RESTART: ctl_o.cmd = CMD_RESTART;
      S_FINISH:    if (sts_i.can_emit) ctl_o.cmd = CMD_FINISH;
      default:     ctl_o.cmd = CMD_NOP;
    endcase
  end

  // State, model-ready flag and item context.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ready_q  <= 1'b0;
      rb_dec_q <= 1'b0;
      flush_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rb_dec_q <= 1'b0;
        flush_q  <= (operation_i != OP_COUNT) && (operation_i != OP_ENCODE);
      end
      if (state_q == S_DEC_WR && sts_i.cnt_one) begin
        rb_dec_q <= 1'b1;
      end
      if (state_q == S_RB_CHK && !sts_i.total_zero) begin
        ready_q <= 1'b1;
      end
      if (state_q == S_FL_RESTART) begin
        ready_q <= 1'b0;
      end
    end
  end

endmodule

>>> src/arithmetic_encoder_semi_static.sv
// A count updates the histogram until the model is built; an encode narrows the interval and
// shifts out settled and pending bits, using two quotient divisions against the running scale.
// A model rebuild makes halving passes over the histogram, then builds the bound table,
// walking the 256-entry histogram memory one entry per cycle; flush emits closing, pending and pad bits.
// One item at a time; a finished result waits in the output register meanwhile.
// Reset is asynchronous, active low; histogram valid bits clear at once, no sweep.
module arithmetic_encoder_semi_static #(
  parameter int unsigned COUNT_WIDTH = aess_pkg::DefCountWidth,
  parameter int unsigned PENDING_MAX = aess_pkg::DefPendingMax,
  parameter int unsigned SCALE_LIMIT = aess_pkg::DefScaleLimit
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aess_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aess_pkg::out_t out_data_o
);
  import aess_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer.
  aess_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  // Stores, arithmetic and output staging.
  aess_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PENDING_MAX (PENDING_MAX),
    .SCALE_LIMIT (SCALE_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .symbol_i    (in_data_i.symbol),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/arithmetic_encoder_semi_static_chk.sv
// Checker of the semi-static arithmetic encoder: predicts coded bytes and compares transfers.
`timescale 1ns / 1ps

module arithmetic_encoder_semi_static_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  aess_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  aess_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             bytes_due_o
);
  import aess_pkg::*;

  localparam int unsigned CountMax  = (1 << DefCountWidth) - 1;
  localparam int unsigned ResultCap = 36;

  // Predicted coder and model state.
  int unsigned hist_q [NumSymbols];
  int unsigned scaled_q [NumSymbols];
  int unsigned bounds_q [NumSymbols+1];
  int unsigned scale_total;
  int unsigned lo_q, hi_q, underflow_q, byte_acc, bit_pos;
  bit          model_built;

  // Results of the item being predicted, and results still to arrive.
  out_t item_bytes [$];
  out_t coded_due [$];
  int   fails;

  assign fail_count_o = fails;
  assign bytes_due_o  = coded_due.size();

  function automatic void add_result(logic [7:0] b, status_e st);
    out_t r;
    if (item_bytes.size() < ResultCap) begin
      r.coded_byte = b;
      r.last_byte  = 1'b0;
      r.status     = st;
      item_bytes.push_back(r);
    end
  endfunction

  function automatic void emit_bit(int unsigned b);
    if (b != 0) byte_acc |= 1 << bit_pos;
    if (bit_pos == 0) begin
      add_result(byte_acc[7:0], STATUS_OK);
      byte_acc = 0;
      bit_pos  = 7;
    end else begin
      bit_pos--;
    end
  endfunction

  // Halve the histogram until it fits the scale limit, then build bounds.
  function automatic void scale_histogram();
    longint unsigned sum;
    int unsigned acc, h;
    bit changed;
    for (int i = 0; i < NumSymbols; i++) scaled_q[i] = hist_q[i];
    forever begin
      sum = 0;
      changed = 0;
      for (int i = 0; i < NumSymbols; i++) sum += scaled_q[i];
      if (sum <= DefScaleLimit) break;
      for (int i = 0; i < NumSymbols; i++) begin
        h = scaled_q[i] >> 1;
        if (h == 0 && hist_q[i] != 0) h = 1;
        if (h != scaled_q[i]) changed = 1;
        scaled_q[i] = h;
      end
      if (!changed) break;
    end
    acc = 0;
    for (int i = 0; i < NumSymbols; i++) begin
      bounds_q[i] = acc;
      acc += scaled_q[i];
    end
    bounds_q[NumSymbols] = acc;
    scale_total = acc & 32'h7FFF;
  endfunction

  function automatic void restart_coder();
    for (int i = 0; i < NumSymbols; i++) hist_q[i] = 0;
    lo_q = 0;
    hi_q = 16'hFFFF;
    underflow_q = 0;
    byte_acc = 0;
    bit_pos = 7;
    model_built = 0;
  endfunction

  // Narrow the interval to one symbol and shift out the settled bits.
  function automatic void encode_symbol(int unsigned s);
    int unsigned span, h, l, b;
    bit ovf;
    ovf  = 0;
    span = hi_q - lo_q + 1;
    h = (lo_q + int'((longint'(span) * bounds_q[s+1]) / scale_total) - 1) & 16'hFFFF;
    l = (lo_q + int'((longint'(span) * bounds_q[s]) / scale_total)) & 16'hFFFF;
    forever begin
      if (((h ^ l) & 16'h8000) == 0) begin
        b = (h & 16'h8000) ? 1 : 0;
        emit_bit(b);
        while (underflow_q > 0) begin
          emit_bit(b ^ 1);
          underflow_q--;
        end
      end else if ((l & 16'h4000) && !(h & 16'h4000)) begin
        if (underflow_q < DefPendingMax) underflow_q++;
        else ovf = 1;
        h |= 16'h4000;
        l &= 16'h3FFF;
      end else begin
        break;
      end
      h = ((h << 1) | 1) & 16'hFFFF;
      l = (l << 1) & 16'hFFFF;
    end
    hi_q = h;
    lo_q = l;
    if (hist_q[s] > 0) begin
      hist_q[s]--;
      if (hist_q[s] == 0) scale_histogram();
    end
    if (ovf) add_result(8'h00, STATUS_OVERFLOW);
  endfunction

  function automatic void predict_item(in_t it);
    int unsigned s, b1;
    s = it.symbol;
    item_bytes.delete();
    if (it.operation == OP_COUNT) begin
      if (!model_built && hist_q[s] < CountMax) hist_q[s]++;
    end else if (it.operation == OP_ENCODE) begin
      if (!model_built) begin
        scale_histogram();
        if (scale_total == 0) add_result(8'h00, STATUS_EMPTY);
        else model_built = 1;
      end
      if (item_bytes.size() == 0) begin
        if (scaled_q[s] == 0 || scale_total == 0) add_result(8'h00, STATUS_EXHAUSTED);
        else encode_symbol(s);
      end
    end else begin
      // Flush: closing bits, pending bits, then pad a partial byte with ones.
      if (!model_built) begin
        add_result(8'h00, STATUS_EMPTY);
      end else begin
        b1 = (lo_q & 16'h4000) ? 1 : 0;
        emit_bit(b1);
        emit_bit(b1 ^ 1);
        while (underflow_q > 0) begin
          emit_bit(b1 ^ 1);
          underflow_q--;
        end
        while (bit_pos != 7) emit_bit(1);
      end
      restart_coder();
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last_byte = 1'b1;
    foreach (item_bytes[i]) coded_due.push_back(item_bytes[i]);
  endfunction

  initial begin
    fails = 0;
    for (int i = 0; i < NumSymbols; i++) scaled_q[i] = 0;
    for (int i = 0; i <= NumSymbols; i++) bounds_q[i] = 0;
    scale_total = 0;
    restart_coder();
  end

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (coded_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Unexpected result: actual %h", out_data_i);
        end else begin
          want = coded_due.pop_front();
          if (want.coded_byte != out_data_i.coded_byte || want.last_byte != out_data_i.last_byte
              || want.status != out_data_i.status) begin
            fails++;
            if (fails <= 10)
              $display("Mismatch: expected byte %h last %b status %0d, actual byte %h last %b status %0d",
                       want.coded_byte, want.last_byte, want.status, out_data_i.coded_byte,
                       out_data_i.last_byte, out_data_i.status);
          end
        end
      end
    end
  end

endmodule

>>> sim/arithmetic_encoder_semi_static_tb.sv
// Testbench top of the semi-static arithmetic encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module arithmetic_encoder_semi_static_tb;
  import aess_pkg::*;

  localparam int CycleLimit = 5000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count, bytes_due;
  int   cycles = 0;
  int   items_sent = 0;
  bit   gaps_on = 1'b1;

  always #6 clk_i = ~clk_i;

  arithmetic_encoder_semi_static u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  arithmetic_encoder_semi_static_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .bytes_due_o  (bytes_due)
  );

  // Random receiver stalls.
  always @(posedge clk_i) out_stall <= gaps_on && ($urandom_range(99) < 7);

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One input transfer, with random gaps ahead of it.
  task automatic send_item(logic [1:0] op, logic [7:0] sym);
    while (gaps_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, symbol: sym};
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // A mostly well-formed block: histogram, encodes drawn from it with occasional stray items, flush.
  task automatic send_block();
    logic [7:0] alpha [8];
    logic [7:0] seen [$];
    int n_alpha, n_cnt, n_enc;
    n_alpha = $urandom_range(1, 8);
    for (int i = 0; i < n_alpha; i++) alpha[i] = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) alpha[0] = 8'h00;
    if ($urandom_range(9) == 0) alpha[n_alpha-1] = 8'hFF;
    n_cnt = $urandom_range(1, 20);
    for (int i = 0; i < n_cnt; i++) begin
      seen.push_back(alpha[$urandom_range(n_alpha-1)]);
      send_item(OP_COUNT, seen[$]);
    end
    n_enc = $urandom_range(1, n_cnt + 2);
    for (int i = 0; i < n_enc; i++) begin
      if ($urandom_range(19) == 0) send_item(OP_COUNT, 8'($urandom_range(255)));
      if ($urandom_range(19) == 0) send_item(OP_ENCODE, 8'($urandom_range(255)));
      else send_item(OP_ENCODE, seen[$urandom_range(seen.size()-1)]);
    end
    send_item($urandom_range(3) == 0 ? 2'd3 : OP_FLUSH, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty model, flush variants, symbol extremes, exhausted symbols.
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_FLUSH, 8'hFF);
    send_item(2'd3, 8'h00);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_COUNT, 8'hFF);
    send_item(OP_COUNT, 8'h80);
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_ENCODE, 8'h07);
    send_item(OP_COUNT, 8'h07);
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'h00);
    send_item(OP_ENCODE, 8'h80);
    send_item(OP_ENCODE, 8'hFF);
    send_item(OP_FLUSH, 8'h55);
    send_item(OP_COUNT, 8'h01);
    send_item(OP_ENCODE, 8'h01);
    send_item(2'd3, 8'hAA);

    // Random part: a stretch without gaps, then gaps on both sides.
    gaps_on = 1'b0;
    while (items_sent < 460) begin
      if (items_sent > 170) gaps_on = 1'b1;
      if ($urandom_range(99) < 85) send_block();
      else send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    in_valid <= 1'b0;

    // Drain the expected results, then allow for a trailing rebuild.
    while (bytes_due != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/aess_pkg.sv
src/aess_ram.sv
src/aess_dp.sv
src/aess_ctrl.sv
src/arithmetic_encoder_semi_static.sv
sim/arithmetic_encoder_semi_static_chk.sv
sim/arithmetic_encoder_semi_static_tb.sv
